>>> hw/rtl/cmc_pkg.sv
// ----------------------------------------------------------------------------
// cmc_pkg: colour model converter shared definitions
// Model codes, queue entry type and small arithmetic helpers.
// ----------------------------------------------------------------------------
package cmc_pkg;

  typedef enum logic [2:0] {
    M_RGB     = 3'd0,
    M_NRGBA   = 3'd1,
    M_NRGBA64 = 3'd2,
    M_GRAY    = 3'd3,
    M_GRAY16  = 3'd4,
    M_CMYK    = 3'd5
  } model_t;

  localparam int QDEPTH     = 4;
  localparam int QIDX_W     = 2;
  localparam int QCNT_W     = 3;
  localparam int DIV_STAGES = 16;

  // pass: data already holds the masked source colour
  // otherwise data holds widened {a, b, g, r}, 16 bits each
  typedef struct packed {
    logic        pass;
    model_t      dst;
    logic [63:0] data;
  } cmc_entry_t;

  // codes 6 and 7 behave as nrgba
  function automatic model_t norm_model(logic [2:0] m);
    model_t r;
    unique case (m)
      3'd0:    r = M_RGB;
      3'd2:    r = M_NRGBA64;
      3'd3:    r = M_GRAY;
      3'd4:    r = M_GRAY16;
      3'd5:    r = M_CMYK;
      default: r = M_NRGBA;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] model_mask(model_t m);
    logic [63:0] r;
    unique case (m)
      M_RGB:     r = 64'h0000_0000_00ff_ffff;
      M_NRGBA64: r = 64'hffff_ffff_ffff_ffff;
      M_GRAY:    r = 64'h0000_0000_0000_00ff;
      M_GRAY16:  r = 64'h0000_0000_0000_ffff;
      default:   r = 64'h0000_0000_ffff_ffff;
    endcase
    return r;
  endfunction

  // p / 0xffff for p <= 0xffff * 0xffff: p = hi*0xffff + (hi + lo)
  function automatic logic [15:0] div_ffff(logic [31:0] p);
    logic [16:0] s;
    logic [16:0] q;
    s = {1'b0, p[31:16]} + {1'b0, p[15:0]};
    q = {1'b0, p[31:16]} + {16'd0, (s >= 17'h0ffff)} + {16'd0, (s >= 17'h1fffe)};
    return q[15:0];
  endfunction

endpackage

>>> hw/rtl/cmc_in_if.sv
// ----------------------------------------------------------------------------
// cmc_in_if: input colour channel
// Valid/ready channel carrying the source model and packed colour.
// ----------------------------------------------------------------------------
interface cmc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  source_model;
  logic [63:0] source_color;

  modport source (output valid, source_model, source_color, input ready);
  modport sink   (input valid, source_model, source_color, output ready);
endinterface

>>> hw/rtl/cmc_out_if.sv
// ----------------------------------------------------------------------------
// cmc_out_if: converted colour channel
// Valid/ready channel carrying the packed colour in the destination model.
// ----------------------------------------------------------------------------
interface cmc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] converted_color;

  modport source (output valid, converted_color, input ready);
  modport sink   (input valid, converted_color, output ready);
endinterface

>>> hw/rtl/cmc_cfg_if.sv
// ----------------------------------------------------------------------------
// cmc_cfg_if: configuration write channel
// Valid/ready channel carrying the destination model register value.
// ----------------------------------------------------------------------------
interface cmc_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] dest_model;

  modport source (output valid, dest_model, input ready);
  modport sink   (input valid, dest_model, output ready);
endinterface

>>> hw/rtl/cmc_front.sv
// ----------------------------------------------------------------------------
// cmc_front: classify and widen
// Decodes models, widens the colour to 16-bit RGBA (with multiply and
// exact divide by 0xffff for nrgba64/cmyk) and pushes into the queue.
// ----------------------------------------------------------------------------
module cmc_front import cmc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        source_model,
  input  logic [63:0]       source_color,
  input  logic [2:0]        dest_model,
  input  logic [QCNT_W-1:0] q_level,
  output logic              push,
  output cmc_entry_t        push_entry
);

  logic        f_v_r;
  logic        pass_r;
  model_t      dst_r;
  logic        mul_r;
  logic [31:0] prod_r [3];
  logic [63:0] dir_r;

  model_t      src;
  model_t      dst;
  logic        pass;
  logic        mul;
  logic [15:0] fac;
  logic [15:0] ch [3];
  logic [63:0] dir;
  logic [QCNT_W:0] used;

  // queue slots in use, counting the item held in the front register
  assign used     = {1'b0, q_level} + {{QCNT_W{1'b0}}, f_v_r};
  assign in_ready = (used < (QCNT_W+1)'(QDEPTH));

  always_comb begin
    src  = norm_model(source_model);
    dst  = norm_model(dest_model);
    pass = (src == dst);
    mul  = !pass && ((src == M_NRGBA64) || (src == M_CMYK));
    if (src == M_CMYK) begin
      fac = ~{source_color[31:24], source_color[31:24]};
      for (int i = 0; i < 3; i++) begin
        ch[i] = ~{source_color[8*i +: 8], source_color[8*i +: 8]};
      end
    end else begin
      fac = source_color[63:48];
      for (int i = 0; i < 3; i++) begin
        ch[i] = source_color[16*i +: 16];
      end
    end
    if (pass) begin
      dir = source_color & model_mask(src);
    end else begin
      unique case (src)
        M_RGB: dir = {16'hffff, {2{source_color[23:16]}}, {2{source_color[15:8]}},
                      {2{source_color[7:0]}}};
        M_GRAY: dir = {16'hffff, {6{source_color[7:0]}}};
        M_GRAY16: dir = {16'hffff, {3{source_color[15:0]}}};
        M_NRGBA64: dir = {source_color[63:48], 48'd0};
        M_CMYK: dir = {16'hffff, 48'd0};
        default: dir = {{2{source_color[31:24]}}, {2{source_color[23:16]}},
                        {2{source_color[15:8]}}, {2{source_color[7:0]}}};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= in_valid && in_ready;
    end
    if (in_valid && in_ready) begin
      pass_r <= pass;
      dst_r  <= dst;
      mul_r  <= mul;
      dir_r  <= dir;
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= ch[i] * fac;
      end
    end
  end

  assign push            = f_v_r;
  assign push_entry.pass = pass_r;
  assign push_entry.dst  = dst_r;
  assign push_entry.data = mul_r ? {dir_r[63:48], div_ffff(prod_r[2]),
                                    div_ffff(prod_r[1]), div_ffff(prod_r[0])}
                                 : dir_r;

endmodule

>>> hw/rtl/cmc_queue.sv
// ----------------------------------------------------------------------------
// cmc_queue: front-to-back decoupling queue
// Small FIFO of widened colours; the front never pushes when full.
// ----------------------------------------------------------------------------
module cmc_queue import cmc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cmc_entry_t        push_entry,
  input  logic              pop,
  output logic              head_valid,
  output cmc_entry_t        head_entry,
  output logic [QCNT_W-1:0] level
);

  cmc_entry_t        mem [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr_r;
  logic [QIDX_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign do_pop     = pop && (cnt_r != '0);
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem[rd_ptr_r];
  assign level      = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + {{(QCNT_W-1){1'b0}}, push} - {{(QCNT_W-1){1'b0}}, do_pop};
    end
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> hw/rtl/cmc_back.sv
// ----------------------------------------------------------------------------
// cmc_back: narrow to destination model
// Luma and simple narrowing in one stage; cmyk divides through a 16-stage
// restoring divider pipeline; output register holds the result.
// ----------------------------------------------------------------------------
module cmc_back import cmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  cmc_entry_t  head_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] converted_color
);

  logic        adv;
  logic        e_v_r;
  cmc_entry_t  e_r;
  logic        out_v_r;
  logic [63:0] out_r;

  // stage-0 decode
  logic [15:0] r, g, b, a, w;
  logic [31:0] luma;
  logic [63:0] plain;
  logic        isdiv;
  logic [15:0] d [3];

  // divider pipeline
  logic        v_r     [DIV_STAGES];
  logic        isdiv_r [DIV_STAGES];
  logic [63:0] plain_r [DIV_STAGES];
  logic [15:0] w_r     [DIV_STAGES];
  logic [15:0] rem_r   [DIV_STAGES][3];
  logic [15:0] nlo_r   [DIV_STAGES][3];
  logic [15:0] q_r     [DIV_STAGES][3];

  assign adv = !out_v_r || out_ready;
  assign pop = adv;

  always_comb begin
    r = e_r.data[15:0];
    g = e_r.data[31:16];
    b = e_r.data[47:32];
    a = e_r.data[63:48];
    w = r;
    if (w < g) w = g;
    if (w < b) w = b;
    luma = 32'd19595 * {16'd0, r} + 32'd38470 * {16'd0, g} + 32'd7471 * {16'd0, b}
           + 32'h8000;
    d[0] = w - r;
    d[1] = w - g;
    d[2] = w - b;
    isdiv = 1'b0;
    if (e_r.pass) begin
      plain = e_r.data;
    end else begin
      unique case (e_r.dst)
        M_RGB:     plain = {40'd0, b[15:8], g[15:8], r[15:8]};
        M_NRGBA64: plain = e_r.data;
        M_GRAY:    plain = {56'd0, luma[31:24]};
        M_GRAY16:  plain = {48'd0, luma[31:16]};
        M_CMYK: begin
          // black has no hue: fixed result, no division
          plain = 64'h0000_0000_ff00_0000;
          isdiv = (w != 16'd0);
        end
        default:   plain = {32'd0, a[15:8], b[15:8], g[15:8], r[15:8]};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      e_v_r   <= head_valid;
      out_v_r <= v_r[DIV_STAGES-1];
    end
    if (adv) begin
      e_r <= head_entry;
      if (isdiv_r[DIV_STAGES-1]) begin
        out_r <= {32'd0, ~w_r[DIV_STAGES-1][15:8], q_r[DIV_STAGES-1][2][15:8],
                  q_r[DIV_STAGES-1][1][15:8], q_r[DIV_STAGES-1][0][15:8]};
      end else begin
        out_r <= plain_r[DIV_STAGES-1];
      end
    end
  end

  // numerator (w - ch) * 0xffff; quotient fits 16 bits since w - ch <= w
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic        v_in, isdiv_in;
    logic [63:0] plain_in;
    logic [15:0] w_in;
    logic [15:0] rem_in [3];
    logic [15:0] nlo_in [3];
    logic [15:0] q_in   [3];
    logic [16:0] t      [3];
    logic        ge     [3];

    always_comb begin
      if (s == 0) begin
        v_in     = e_v_r;
        isdiv_in = isdiv;
        plain_in = plain;
        w_in     = w;
        for (int c = 0; c < 3; c++) begin
          rem_in[c] = d[c] - {15'd0, (d[c] != 16'd0)};
          nlo_in[c] = 16'd0 - d[c];
          q_in[c]   = 16'd0;
        end
      end else begin
        v_in     = v_r[(s == 0) ? 0 : s-1];
        isdiv_in = isdiv_r[(s == 0) ? 0 : s-1];
        plain_in = plain_r[(s == 0) ? 0 : s-1];
        w_in     = w_r[(s == 0) ? 0 : s-1];
        for (int c = 0; c < 3; c++) begin
          rem_in[c] = rem_r[(s == 0) ? 0 : s-1][c];
          nlo_in[c] = nlo_r[(s == 0) ? 0 : s-1][c];
          q_in[c]   = q_r[(s == 0) ? 0 : s-1][c];
        end
      end
      for (int c = 0; c < 3; c++) begin
        t[c]  = {rem_in[c], nlo_in[c][15]};
        ge[c] = (t[c] >= {1'b0, w_in});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv) begin
        v_r[s] <= v_in;
      end
      if (adv) begin
        isdiv_r[s] <= isdiv_in;
        plain_r[s] <= plain_in;
        w_r[s]     <= w_in;
        for (int c = 0; c < 3; c++) begin
          rem_r[s][c] <= ge[c] ? 16'(t[c] - {1'b0, w_in}) : t[c][15:0];
          nlo_r[s][c] <= {nlo_in[c][14:0], 1'b0};
          q_r[s][c]   <= {q_in[c][14:0], ge[c]};
        end
      end
    end
  end

  assign out_valid       = out_v_r;
  assign converted_color = out_r;

endmodule

>>> hw/rtl/color_model_converter.sv
// ----------------------------------------------------------------------------
// color_model_converter: packed colour model conversion
// Converts one colour per transaction into the configured destination model.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   - transaction carries source_model and source_color (packed,
//             first channel lowest). Accepted on valid & ready.
//   out_ch  - one converted_color per input transaction, in input order.
//   cfg_ch  - writes dest_model; always ready. Write only when the block
//             is idle (all results delivered).
// Throughput: one transaction per cycle, sustained, whatever the models,
//   while out_ch.ready is high. From acceptance to out_ch.valid an item
//   passes the widening stage, the queue, the narrowing stage and the
//   16-stage restoring divider used for the cmyk division by max(r, g, b).
//   Every item walks the same pipeline, so order is kept.
// Reset (rst_n low, synchronous): pipeline and queue emptied, dest_model
//   returns to nrgba.
// Stall: with a result waiting and out_ch.ready low the back pipeline holds;
//   the front keeps taking transactions until the 4-entry queue fills, then drops in ready.
// ----------------------------------------------------------------------------
module color_model_converter import cmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cmc_in_if.sink    in_ch,
  cmc_out_if.source out_ch,
  cmc_cfg_if.sink   cfg_ch
);

  logic [2:0]        dest_model_r;
  logic              push;
  cmc_entry_t        push_entry;
  logic              pop;
  logic              head_valid;
  cmc_entry_t        head_entry;
  logic [QCNT_W-1:0] q_level;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_model_r <= M_NRGBA;
    end else if (cfg_ch.valid) begin
      dest_model_r <= cfg_ch.dest_model;
    end
  end

  // front: decode and widen to 16-bit RGBA
  cmc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .source_model (in_ch.source_model),
    .source_color (in_ch.source_color),
    .dest_model   (dest_model_r),
    .q_level      (q_level),
    .push         (push),
    .push_entry   (push_entry)
  );

  // decoupling queue
  cmc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .level      (q_level)
  );

  // back: narrow, divide, hold result
  cmc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_entry      (head_entry),
    .pop             (pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .converted_color (out_ch.converted_color)
  );

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= QCNT_W'(QDEPTH))
    else $error("queue level beyond depth");

  a_accept_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> push)
    else $error("accepted transaction not pushed");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> q_level < QCNT_W'(QDEPTH))
    else $error("push into full queue");
`endif

endmodule

>>> verif/tb_color_model_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_color_model_converter: self-checking bench for the colour model converter
// Drives random and directed colours in every source model through the block
// under each destination model, predicts every result and compares in order.
// ----------------------------------------------------------------------------
module tb_color_model_converter;
  import cmc_pkg::*;

  typedef struct {
    logic [2:0]  model;
    logic [63:0] color;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cmc_in_if  in_ch();
  cmc_out_if out_ch();
  cmc_cfg_if cfg_ch();

  color_model_converter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #5 clk = ~clk;

  // Pending input transactions, filled by the stimulus block
  pixel_t      pixel_queue[$];
  // Converted colours still owed by the block
  logic [63:0] colour_expected[$];
  logic [2:0]  dest_sel;   // predictor copy of dest_model
  int          mismatches = 0;
  int          drive_gap = 0;
  int          accept_gap = 0;
  bit          hold_input = 1'b0;
  bit          cfg_pending = 1'b0;
  bit          in_taken = 1'b0;  // input transaction accepted at the last rising edge
  logic [2:0]  cfg_value;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("mismatch: %s got %h expected %h at %0t", what, got, exp_val, $realtime);
    mismatches++;
  endtask

  function automatic logic [2:0] fold_model(logic [2:0] m);
    return (m > M_CMYK) ? M_NRGBA : m;
  endfunction

  function automatic logic [63:0] width_mask(logic [2:0] m);
    case (m)
      M_RGB:     return 64'hff_ffff;
      M_NRGBA64: return '1;
      M_GRAY:    return 64'hff;
      M_GRAY16:  return 64'hffff;
      default:   return 64'hffff_ffff;
    endcase
  endfunction

  // Widen to 16-bit rgba then narrow to the destination model; a colour already in that model is only masked
  function automatic logic [63:0] convert_colour(logic [2:0] src_raw, logic [63:0] v,
                                                 logic [2:0] dst_raw);
    logic [2:0]  src, dst;
    logic [63:0] r, g, b, a, w, luma;
    src = fold_model(src_raw);
    dst = fold_model(dst_raw);
    if (src == dst) return v & width_mask(src);
    case (src)
      M_RGB, M_GRAY, M_GRAY16: begin
        if (src == M_GRAY16) begin
          r = v[15:0];
          g = r;
          b = r;
        end else if (src == M_GRAY) begin
          r = v[7:0] * 64'h101;
          g = r;
          b = r;
        end else begin
          r = v[7:0] * 64'h101;
          g = v[15:8] * 64'h101;
          b = v[23:16] * 64'h101;
        end
        a = 64'hffff;
      end
      M_NRGBA64: begin
        a = v[63:48];
        r = v[15:0] * a / 64'hffff;
        g = v[31:16] * a / 64'hffff;
        b = v[47:32] * a / 64'hffff;
      end
      M_CMYK: begin
        w = 64'hffff - v[31:24] * 64'h101;
        r = (64'hffff - v[7:0] * 64'h101) * w / 64'hffff;
        g = (64'hffff - v[15:8] * 64'h101) * w / 64'hffff;
        b = (64'hffff - v[23:16] * 64'h101) * w / 64'hffff;
        a = 64'hffff;
      end
      default: begin
        r = v[7:0] * 64'h101;
        g = v[15:8] * 64'h101;
        b = v[23:16] * 64'h101;
        a = v[31:24] * 64'h101;
      end
    endcase
    luma = 64'd19595 * r + 64'd38470 * g + 64'd7471 * b + 64'h8000;
    case (dst)
      M_RGB:     return (r >> 8) | ((g >> 8) << 8) | ((b >> 8) << 16);
      M_NRGBA64: return r | (g << 16) | (b << 32) | (a << 48);
      M_GRAY:    return (luma >> 24) & 64'hff;
      M_GRAY16:  return (luma >> 16) & 64'hffff;
      M_CMYK: begin
        w = r;
        if (w < g) w = g;
        if (w < b) w = b;
        // black has no hue: all ink in k
        if (w == 0) return 64'hff00_0000;
        return ((((w - r) * 64'hffff / w) >> 8))
             | ((((w - g) * 64'hffff / w) >> 8) << 8)
             | ((((w - b) * 64'hffff / w) >> 8) << 16)
             | (((64'hffff - w) >> 8) << 24);
      end
      default:   return (r >> 8) | ((g >> 8) << 8) | ((b >> 8) << 16) | ((a >> 8) << 24);
    endcase
  endfunction

  // Driver: one transaction at a time, random gap before each
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // holding until accepted
    end else begin
      if (in_ch.valid) drive_gap = $urandom_range(0, 7) * ($urandom_range(0, 3) != 0);
      if (drive_gap > 0) begin
        drive_gap--;
        in_ch.valid <= 1'b0;
      end else if (pixel_queue.size() > 0 && !hold_input) begin
        in_ch.valid        <= 1'b1;
        in_ch.source_model <= pixel_queue[0].model;
        in_ch.source_color <= pixel_queue[0].color;
        void'(pixel_queue.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (accept_gap > 0) begin
      accept_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_ch.valid && out_ch.ready)
        accept_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    end
  end

  // Config writer
  always @(negedge clk) begin
    if (!rst_n) cfg_ch.valid <= 1'b0;
    else if (cfg_pending && !(cfg_ch.valid && cfg_ch.ready)) begin
      cfg_ch.valid      <= 1'b1;
      cfg_ch.dest_model <= cfg_value;
    end else cfg_ch.valid <= 1'b0;
  end

  // Monitor: prediction on acceptance, check on result
  always @(posedge clk) begin
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        dest_sel = cfg_ch.dest_model;
        cfg_pending = 1'b0;
      end
      if (in_ch.valid && in_ch.ready)
        colour_expected.push_back(convert_colour(in_ch.source_model, in_ch.source_color,
                                                 dest_sel));
      if (out_ch.valid && out_ch.ready) begin
        if (colour_expected.size() == 0)
          report_mismatch("unexpected result", out_ch.converted_color, 64'h0);
        else if (out_ch.converted_color !== colour_expected[0])
          report_mismatch("converted_color", out_ch.converted_color, colour_expected[0]);
        if (colour_expected.size() > 0) void'(colour_expected.pop_front());
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random colour: mostly clean for the model, sometimes junk in the upper bits,
  // and some channels forced to extremes
  function automatic pixel_t random_pixel();
    pixel_t p;
    logic [63:0] v;
    p.model = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
    v = rand64();
    for (int i = 0; i < 8; i++)
      case ($urandom_range(0, 5))
        0: v[i*8 +: 8] = 8'h00;
        1: v[i*8 +: 8] = 8'hff;
        default: ;
      endcase
    if ($urandom_range(0, 3) != 0) v &= width_mask(fold_model(p.model));
    p.color = v;
    return p;
  endfunction

  task automatic wait_idle();
    while (pixel_queue.size() > 0 || in_ch.valid || colour_expected.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_dest(input logic [2:0] m);
    wait_idle();
    cfg_value = m;
    cfg_pending = 1'b1;
    while (cfg_pending) @(posedge clk);
  endtask

  task automatic push_pixel(input logic [2:0] m, input logic [63:0] v);
    pixel_t p;
    p.model = m;
    p.color = v;
    pixel_queue.push_back(p);
  endtask

  logic [2:0] dest_order[8] = '{M_NRGBA, M_RGB, M_NRGBA64, M_GRAY, M_GRAY16, M_CMYK, 3'd7, 3'd6};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.source_model = '0;
    in_ch.source_color = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.dest_model = '0;
    dest_sel = M_NRGBA;  // register value out of reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every source model at black, white and all-ones, under reset dest
    for (int m = 0; m < 8; m++) begin
      push_pixel(3'(m), 64'h0);
      push_pixel(3'(m), '1);
      push_pixel(3'(m), width_mask(fold_model(3'(m))));
    end

    for (int d = 0; d < 8; d++) begin
      if (d > 0) write_dest(dest_order[d]);
      // black into cmyk and nrgba64 with zero alpha
      push_pixel(M_RGB, 64'h0);
      push_pixel(M_NRGBA64, 64'h0000_ffff_ffff_ffff);
      push_pixel(M_CMYK, 64'hff00_0000);
      for (int i = 0; i < 280; i++) pixel_queue.push_back(random_pixel());
      if (d == 3) begin
        // let traffic build up, then pause the sender until the pipeline has drained
        while (pixel_queue.size() > 140) @(posedge clk);
        hold_input = 1'b1;
        while (colour_expected.size() > 0 || in_ch.valid) @(posedge clk);
        hold_input = 1'b0;
      end
    end
    wait_idle();
    if (mismatches == 0 && colour_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/cmc_pkg.sv
hw/rtl/cmc_in_if.sv
hw/rtl/cmc_out_if.sv
hw/rtl/cmc_cfg_if.sv
hw/rtl/cmc_front.sv
hw/rtl/cmc_queue.sv
hw/rtl/cmc_back.sv
hw/rtl/color_model_converter.sv
verif/tb_color_model_converter.sv
